// File: sv/fjd_pkg.sv
`timescale 1ns / 1ps

package fjd_pkg;

  // Q1.16 unit and widths of the datapath
  localparam int Q_W   = 17;
  localparam int SUM_W = 30;
  localparam int CFG_W = 32;
  localparam int IDX_W = 2;

  localparam logic [Q_W-1:0]   ONE_Q16 = 17'd65536;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Measure modes; the unused code behaves as generalized
  localparam logic [1:0] MODE_GEN = 2'd0;
  localparam logic [1:0] MODE_ISO = 2'd1;
  localparam logic [1:0] MODE_AVG = 2'd2;

  // Register indexes of the configuration port
  localparam logic [IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_ISO   = 2'd1;
  localparam logic [IDX_W-1:0] CFG_LOW   = 2'd2;
  localparam logic [IDX_W-1:0] CFG_GAIN  = 2'd3;

  // Finished sums of one comparison, handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] uni;
    logic [SUM_W-1:0] inter;
  } sums_t;

  // Queue handshake between front and back
  typedef struct packed {
    logic  push;
    sums_t data;
  } q_wr_t;

  typedef struct packed {
    logic  full;
    logic  valid;
    sums_t data;
  } q_rd_t;

  // Divider sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } div_state_t;

endpackage

// File: sv/fjd_front.sv
`timescale 1ns / 1ps

module fjd_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_first,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_second,
  input  logic                          in_last_sample,
  input  logic [1:0]                    measure_mode,
  input  logic [fjd_pkg::Q_W-1:0]       iso_level,
  input  logic signed [15:0]            range_low,
  input  logic [31:0]                   range_gain,
  input  logic                          q_full,
  output fjd_pkg::q_wr_t                q_wr
);
  import fjd_pkg::*;

  localparam int MW = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
  localparam int DW = MW + 1;
  localparam int PW = DW - 1 + 32;

  logic signed [DW-1:0] diff_a, diff_b;
  logic [DW-2:0]        mag_a, mag_b;
  logic                 adv;

  logic [PW-1:0]        s1_prod_a_r, s1_prod_b_r;
  logic                 s1_last_r, s1_valid_r;

  logic [Q_W-1:0]       na, nb, ta, tb, hi, lo, dab, inc_i, inc_u;
  logic [Q_W-1:0]       s2_inc_i_r, s2_inc_u_r;
  logic                 s2_last_r, s2_valid_r;

  logic [SUM_W-1:0]     inter_r, uni_r, inter_nxt, uni_nxt;

  function automatic logic [Q_W-1:0] sat_norm(input logic [PW-1:0] p);
    logic [Q_W-1:0] res;
    if (p[PW-1:16] > (PW-16)'(ONE_Q16)) res = ONE_Q16;
    else                                res = p[Q_W+15:16];
    return res;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic [Q_W-1:0]   v);
    logic [SUM_W:0] t;
    t = {1'b0, s} + (SUM_W+1)'(v);
    return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
  endfunction

  // Hold the whole front while a finished comparison cannot enter the queue
  assign adv      = !(s2_valid_r && s2_last_r && q_full);
  assign in_stall = !adv;

  // Offset each sample; zero out anything at or below the low end
  assign diff_a = {{(DW-SAMPLE_BITS){in_sample_first[SAMPLE_BITS-1]}}, in_sample_first}
                - {{(DW-16){range_low[15]}}, range_low};
  assign diff_b = {{(DW-SAMPLE_BITS){in_sample_second[SAMPLE_BITS-1]}}, in_sample_second}
                - {{(DW-16){range_low[15]}}, range_low};
  assign mag_a  = (diff_a > 0) ? diff_a[DW-2:0] : '0;
  assign mag_b  = (diff_b > 0) ? diff_b[DW-2:0] : '0;

  // Stage 1: scale by the gain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod_a_r <= PW'(mag_a) * PW'(range_gain);
      s1_prod_b_r <= PW'(mag_b) * PW'(range_gain);
      s1_last_r   <= in_last_sample;
    end
  end

  // Stage 2: saturate, threshold in iso mode, and form the two increments
  always_comb begin
    na    = sat_norm(s1_prod_a_r);
    nb    = sat_norm(s1_prod_b_r);
    ta    = na;
    tb    = nb;
    if (measure_mode == MODE_ISO) begin
      ta = (na < iso_level) ? ONE_Q16 : '0;
      tb = (nb < iso_level) ? ONE_Q16 : '0;
    end
    hi    = (ta > tb) ? ta : tb;
    lo    = (ta > tb) ? tb : ta;
    dab   = hi - lo;
    if (measure_mode == MODE_AVG) begin
      inc_i = ONE_Q16 - dab;
      inc_u = ONE_Q16;
    end else begin
      inc_i = ONE_Q16 - hi;
      inc_u = ONE_Q16 - lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_inc_i_r <= inc_i;
      s2_inc_u_r <= inc_u;
      s2_last_r  <= s1_last_r;
    end
  end

  // Accumulate; on the last pair hand the sums on and clear them
  assign inter_nxt = sat_add(inter_r, s2_inc_i_r);
  assign uni_nxt   = sat_add(uni_r, s2_inc_u_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inter_r <= '0;
      uni_r   <= '0;
    end else if (adv && s2_valid_r) begin
      if (s2_last_r) begin
        inter_r <= '0;
        uni_r   <= '0;
      end else begin
        inter_r <= inter_nxt;
        uni_r   <= uni_nxt;
      end
    end
  end

  assign q_wr.push       = adv && s2_valid_r && s2_last_r;
  assign q_wr.data.uni   = uni_nxt;
  assign q_wr.data.inter = inter_nxt;

endmodule

// File: sv/fjd_queue.sv
`timescale 1ns / 1ps

module fjd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  fjd_pkg::q_wr_t q_wr,
  input  logic           pop,
  output fjd_pkg::q_rd_t q_rd
);
  import fjd_pkg::*;

  sums_t      slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_pop;

  assign do_pop     = pop && (cnt_r != 2'd0);
  assign q_rd.full  = (cnt_r == 2'd2);
  assign q_rd.valid = (cnt_r != 2'd0);
  assign q_rd.data  = slot_r[rd_ptr_r];

  // Store a transaction at the write pointer
  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      slot_r[wr_ptr_r] <= q_wr.data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (q_wr.push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)    rd_ptr_r <= !rd_ptr_r;
      case ({q_wr.push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: sv/fjd_back.sv
`timescale 1ns / 1ps

module fjd_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fjd_pkg::q_rd_t          q_rd,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [fjd_pkg::Q_W-1:0] out_distance,
  output logic                    out_union_empty
);
  import fjd_pkg::*;

  div_state_t       state_r, state_nxt;
  logic [SUM_W:0]   rem_r;
  logic [SUM_W-1:0] dvs_r;
  logic [Q_W-1:0]   quo_r;
  logic [4:0]       cnt_r;
  logic             empty_r;
  logic             out_valid_r;
  logic [Q_W-1:0]   out_distance_r;
  logic             out_union_empty_r;
  logic             ge;
  logic [SUM_W:0]   rem_sub;
  logic             out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign pop      = (state_r == ST_IDLE) && q_rd.valid;

  // One quotient bit a step: compare, subtract, shift
  assign ge      = rem_r >= {1'b0, dvs_r};
  assign rem_sub = ge ? (rem_r - {1'b0, dvs_r}) : rem_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (q_rd.valid)      state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == 5'd0)   state_nxt = ST_HOLD;
      ST_HOLD: if (out_free)        state_nxt = ST_IDLE;
      default:                      state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Load the divider from the queue, then iterate
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        rem_r   <= (q_rd.data.uni >= q_rd.data.inter)
                   ? {1'b0, q_rd.data.uni - q_rd.data.inter} : '0;
        dvs_r   <= q_rd.data.uni;
        empty_r <= (q_rd.data.uni == '0);
        quo_r   <= '0;
        cnt_r   <= 5'(Q_W - 1);
      end
      ST_DIV: begin
        rem_r <= {rem_sub[SUM_W-1:0], 1'b0};
        quo_r <= {quo_r[Q_W-2:0], ge};
        cnt_r <= cnt_r - 5'd1;
      end
      default: begin
        rem_r <= rem_r;
      end
    endcase
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_HOLD && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_HOLD && out_free) begin
      out_distance_r    <= empty_r ? ONE_Q16 : quo_r;
      out_union_empty_r <= empty_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_distance    = out_distance_r;
  assign out_union_empty = out_union_empty_r;

endmodule

// File: sv/fuzzy_jaccard_distance.sv
`timescale 1ns / 1ps
// Throughput: one sample pair per cycle while in_stall is low; the 17-step restoring
// divider computes one distance at a time and takes the next comparison only once its
// result is in the output register; a two-entry queue absorbs short comparisons.
// Reset: synchronous, active low; clears sums, queue, divider and output valid,
// and loads the configuration defaults.
module fuzzy_jaccard_distance #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_first,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_second,
  input  logic                          in_last_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fjd_pkg::Q_W-1:0]       out_distance,
  output logic                          out_union_empty,
  input  logic                          cfg_we,
  input  logic [fjd_pkg::IDX_W-1:0]     cfg_index,
  input  logic [fjd_pkg::CFG_W-1:0]     cfg_wdata
);
  import fjd_pkg::*;

  logic [1:0]         mode_r;
  logic [Q_W-1:0]     iso_r;
  logic signed [15:0] low_r;
  logic [31:0]        gain_r;
  q_wr_t              q_wr;
  q_rd_t              q_rd;
  logic               q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_GEN;
      iso_r  <= 17'd32768;
      low_r  <= '0;
      gain_r <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE: mode_r <= cfg_wdata[1:0];
        CFG_ISO:  iso_r  <= cfg_wdata[Q_W-1:0];
        CFG_LOW:  low_r  <= cfg_wdata[15:0];
        CFG_GAIN: gain_r <= cfg_wdata[31:0];
        default:  mode_r <= mode_r;
      endcase
    end
  end

  fjd_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_first  (in_sample_first),
    .in_sample_second (in_sample_second),
    .in_last_sample   (in_last_sample),
    .measure_mode     (mode_r),
    .iso_level        (iso_r),
    .range_low        (low_r),
    .range_gain       (gain_r),
    .q_full           (q_rd.full),
    .q_wr             (q_wr)
  );

  fjd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .q_rd  (q_rd)
  );

  fjd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_rd            (q_rd),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_distance    (out_distance),
    .out_union_empty (out_union_empty)
  );

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_wr.push && q_rd.full))
    else $error("queue overflow");

  // Distance stays within 0..1.0
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_distance <= ONE_Q16))
    else $error("distance out of range");

  // An empty union always reports a distance of 1.0
  a_empty_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_union_empty) |-> (out_distance == ONE_Q16))
    else $error("empty union without full distance");

  // Pop only while the queue holds a transaction
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_rd.valid)
    else $error("pop from empty queue");

endmodule
